// ----- rtl/core/lge_pkg.sv -----
`default_nettype none
package lge_pkg;
  localparam int AgeW = 8;
  localparam int GenW = 32;
  localparam int DimW = 7;
  localparam int CoordW = 6;
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_TOGGLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_STEP   = 2'd3;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [AgeW-1:0]   age_in;
  } lge_in_t;

  typedef struct packed {
    logic [AgeW-1:0] age_out;
    logic [GenW-1:0] generation;
    logic            out_of_range;
  } lge_out_t;
endpackage
`default_nettype wire

// ----- rtl/core/life_generation_engine_unit.sv -----
`default_nettype none
// Grid of cell ages under the B3/S23 rule, held in two memory banks
// (current and next generation) that swap roles after each step. A
// write, toggle or read passes through a read state, a write state and
// a done state before its result is registered. A step on a W by H
// active grid has one shared memory read port visit nine cells per
// updated cell, in a read state and an accumulate state each, plus
// one write state; then a copy pass, a read and a write state per cell,
// walks the whole array to carry over the region outside the active
// grid. Every request gives one result, strobed on out_valid for one
// cycle; the receiver cannot stall it. After reset a clearing pass
// over all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) addresses
// (MAX_ROWS*MAX_COLS for power-of-two sizes) zeroes both banks
// while busy is high.
module life_generation_engine_unit
  import lge_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire lge_in_t  in_req,
  output logic          out_valid,
  output lge_out_t      out_res,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_index,
  input  wire logic [DimW-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = RW + CW;
  localparam int CXW = CW + 2;
  localparam int RXW = RW + 2;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ARD   = 4'd2;
  localparam logic [3:0] S_AWR   = 4'd3;
  localparam logic [3:0] S_NRD   = 4'd4;
  localparam logic [3:0] S_NACC  = 4'd5;
  localparam logic [3:0] S_NWR   = 4'd6;
  localparam logic [3:0] S_CPRD  = 4'd7;
  localparam logic [3:0] S_CPWR  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [DimW-1:0] width_r, height_r;
  logic [GenW-1:0] gen_r;
  logic bank_r;
  lge_in_t req_r;
  logic [AW-1:0] clr_r;
  logic [CXW-1:0] cc_r;
  logic [RXW-1:0] rr_r;
  logic [3:0] k_r;
  logic [3:0] cnt_r;
  logic       nvalid_r;
  logic [AgeW-1:0] self_r;
  logic [AgeW-1:0] rdata_r;
  logic            rbank_nz;
  logic [AgeW-1:0] mem0 [2**AW];
  logic [AgeW-1:0] mem1 [2**AW];

  // effective grid dims
  logic [CXW-1:0] w_eff;
  logic [RXW-1:0] h_eff;
  always_comb begin
    if (width_r == '0) w_eff = CXW'(1);
    else if (32'(width_r) > MAX_COLS) w_eff = CXW'(MAX_COLS);
    else w_eff = CXW'(width_r);
    if (height_r == '0) h_eff = RXW'(1);
    else if (32'(height_r) > MAX_ROWS) h_eff = RXW'(MAX_ROWS);
    else h_eff = RXW'(height_r);
  end

  // request coordinates against grid
  logic req_oor;
  assign req_oor = (CXW'(req_r.col) >= w_eff) || (RXW'(req_r.row) >= h_eff)
                || (32'(req_r.col) >= MAX_COLS) || (32'(req_r.row) >= MAX_ROWS);
  logic [AW-1:0] req_addr;
  assign req_addr = {RW'(req_r.row), CW'(req_r.col)};

  // neighbor offset for step k (0..8, 4 is the cell itself)
  logic [1:0] kc, kr;
  always_comb begin
    case (k_r)
      4'd0: begin kc = 2'd0; kr = 2'd0; end
      4'd1: begin kc = 2'd1; kr = 2'd0; end
      4'd2: begin kc = 2'd2; kr = 2'd0; end
      4'd3: begin kc = 2'd0; kr = 2'd1; end
      4'd4: begin kc = 2'd1; kr = 2'd1; end
      4'd5: begin kc = 2'd2; kr = 2'd1; end
      4'd6: begin kc = 2'd0; kr = 2'd2; end
      4'd7: begin kc = 2'd1; kr = 2'd2; end
      4'd8: begin kc = 2'd2; kr = 2'd2; end
      default: begin kc = 2'd1; kr = 2'd1; end
    endcase
  end

  logic [CXW-1:0] nc;
  logic [RXW-1:0] nr;
  logic nin;
  always_comb begin
    nc = cc_r + CXW'(kc) - CXW'(1);
    nr = rr_r + RXW'(kr) - RXW'(1);
    nin = !nc[CXW-1] && !nr[RXW-1] && (nc < w_eff) && (nr < h_eff);
  end
  logic [AW-1:0] cell_addr;
  assign cell_addr = {rr_r[RW-1:0], cc_r[CW-1:0]};

  // copy pass region: cells outside the active grid
  logic cp_out;
  assign cp_out = (cc_r >= w_eff) || (rr_r >= h_eff);

  // read address mux
  logic [AW-1:0] raddr;
  always_comb begin
    if (state_r == S_NRD) raddr = {nr[RW-1:0], nc[CW-1:0]};
    else if (state_r == S_CPRD) raddr = cell_addr;
    else raddr = req_addr;
  end

  // next age of the current cell
  logic [AgeW-1:0] new_age;
  always_comb begin
    if (self_r != '0) begin
      if (cnt_r == 4'd2 || cnt_r == 4'd3)
        new_age = (self_r == '1) ? self_r : self_r + AgeW'(1);
      else new_age = '0;
    end else begin
      new_age = (cnt_r == 4'd3) ? AgeW'(1) : '0;
    end
  end

  // memory banks, registered read
  logic [AgeW-1:0] rd0_r, rd1_r;
  logic [AgeW-1:0] rd;
  assign rd = bank_r ? rd1_r : rd0_r;
  assign rbank_nz = (rd != '0);

  // memory write control
  logic we0, we1;
  logic [AW-1:0] waddr;
  logic [AgeW-1:0] wdata;
  always_comb begin
    we0 = 1'b0; we1 = 1'b0; waddr = req_addr; wdata = req_r.age_in;
    case (state_r)
      S_CLR: begin
        we0 = 1'b1; we1 = 1'b1; waddr = clr_r; wdata = '0;
      end
      S_AWR: begin
        if (!req_oor && req_r.op != OP_READ) begin
          we0 = !bank_r; we1 = bank_r;
          wdata = (req_r.op == OP_WRITE) ? req_r.age_in
                : ((rd == '0) ? AgeW'(1) : '0);
        end
      end
      S_NWR: begin
        we0 = bank_r; we1 = !bank_r; waddr = cell_addr; wdata = new_age;
      end
      S_CPWR: begin
        if (cp_out) begin
          we0 = bank_r; we1 = !bank_r; waddr = cell_addr; wdata = rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we0) mem0[waddr] <= wdata;
    if (we1) mem1[waddr] <= wdata;
    rd0_r <= mem0[raddr];
    rd1_r <= mem1[raddr];
  end

  // sequencer
  logic last_cell;
  assign last_cell = (cc_r == w_eff - CXW'(1)) && (rr_r == h_eff - RXW'(1));
  logic last_cp;
  assign last_cp = (32'(cc_r) == MAX_COLS - 1) && (32'(rr_r) == MAX_ROWS - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: if (start) state_nxt = (in_req.op == OP_STEP) ? S_NRD : S_ARD;
      S_ARD:  state_nxt = S_AWR;
      S_AWR:  state_nxt = S_DONE;
      S_NRD:  state_nxt = S_NACC;
      S_NACC: state_nxt = (k_r == 4'd8) ? S_NWR : S_NRD;
      S_NWR:  state_nxt = last_cell ? S_CPRD : S_NRD;
      S_CPRD: state_nxt = S_CPWR;
      S_CPWR: state_nxt = last_cp ? S_DONE : S_CPRD;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      width_r  <= DimW'(64);
      height_r <= DimW'(64);
      gen_r    <= '0;
      bank_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (state_r == S_CLR) clr_r <= clr_r + AW'(1);
      // take register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
      end
      // capture request, reset sweep position
      if (state_r == S_IDLE && start) begin
        req_r <= in_req;
        cc_r <= '0; rr_r <= '0; k_r <= '0; cnt_r <= '0; nvalid_r <= 1'b0;
      end
      if (state_r == S_AWR) rdata_r <= rd;
      if (state_r == S_NRD) nvalid_r <= nin;
      // accumulate neighbor count
      if (state_r == S_NACC) begin
        if (k_r == 4'd4) self_r <= rd;
        else if (nvalid_r && rbank_nz) cnt_r <= cnt_r + 4'd1;
        k_r <= k_r + 4'd1;
      end
      // advance cell
      if (state_r == S_NWR) begin
        k_r <= '0; cnt_r <= '0;
        if (last_cell) begin
          cc_r <= '0; rr_r <= '0;
        end else if (cc_r == w_eff - CXW'(1)) begin
          cc_r <= '0; rr_r <= rr_r + RXW'(1);
        end else cc_r <= cc_r + CXW'(1);
      end
      if (state_r == S_CPRD) rdata_r <= '0;
      if (state_r == S_CPWR) begin
        if (32'(cc_r) == MAX_COLS - 1) begin
          cc_r <= '0; rr_r <= rr_r + RXW'(1);
        end else cc_r <= cc_r + CXW'(1);
        if (last_cp) begin
          bank_r <= !bank_r;
          gen_r  <= gen_r + GenW'(1);
        end
      end
      // emit result
      if (state_r == S_DONE) begin
        out_valid <= 1'b1;
        if (req_r.op == OP_STEP) begin
          out_res.age_out <= '0;
          out_res.out_of_range <= 1'b0;
        end else begin
          out_res.out_of_range <= req_oor;
          out_res.age_out <= req_oor ? '0 : (req_r.op == OP_WRITE) ? req_r.age_in
            : (req_r.op == OP_TOGGLE) ? ((rdata_r == '0) ? AgeW'(1) : '0) : rdata_r;
        end
        out_res.generation <= gen_r;
      end
    end
  end

  // hold off requests and register writes outside idle
  always_comb busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

endmodule
`default_nettype wire
